### design/rcht_pkg.sv
package rcht_pkg;

  localparam int SLOTS        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int HANDLE_WIDTH = 5;
  localparam int IDX_WIDTH    = $clog2(SLOTS);

  typedef logic [1:0]              opcode_t;
  typedef logic [1:0]              status_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [IDX_WIDTH-1:0]    idx_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [DATA_WIDTH-1:0]   data_t;

  localparam opcode_t OP_ALLOC = 2'd0;
  localparam opcode_t OP_REF   = 2'd1;
  localparam opcode_t OP_UNREF = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;
  localparam status_t ST_SAT  = 2'd3;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    opcode_t opcode;
    handle_t slot_handle;
    data_t   item_value;
  } in_item_t;

  typedef struct packed {
    handle_t result_handle;
    status_t status;
    count_t  ref_count;
    logic    slot_freed;
    data_t   slot_value;
  } out_item_t;

  typedef struct packed {
    logic set;
    logic clr;
    idx_t idx;
  } map_upd_t;

  typedef struct packed {
    logic found;
    idx_t idx;
  } map_free_t;

endpackage

### design/refcounted_handle_table_core.sv
// A transaction accepted in the idle state reads the count and data memories; the execute
// state forms the result and registers its strobe. Busy is high for the cycle after accept,
// while the memories are read, modified and written back; no start is accepted then.
// Reset: synchronous, active low; clears the slot occupancy map, so every slot is free.
// The result strobe lasts one cycle and the receiver cannot stall.
module refcounted_handle_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rcht_pkg::in_item_t  in_item,
  output logic                out_valid,
  output rcht_pkg::out_item_t out_item
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                     state_r, state_nxt;
  rcht_pkg::opcode_t          op_r, op_nxt;
  rcht_pkg::handle_t          handle_r, handle_nxt;
  rcht_pkg::data_t            value_r, value_nxt;
  rcht_pkg::idx_t             idx_r, idx_nxt;
  logic                       full_r, full_nxt;
  logic                       bad_r, bad_nxt;
  logic                       out_valid_r, out_valid_nxt;
  rcht_pkg::out_item_t        out_r, out_nxt;

  logic [rcht_pkg::SLOTS-1:0] used;
  rcht_pkg::map_free_t        free_slot;
  rcht_pkg::map_upd_t         upd;

  logic                       accept;
  rcht_pkg::idx_t             rd_idx;
  rcht_pkg::count_t           cnt_rd;
  rcht_pkg::data_t            data_rd;
  logic                       cnt_we;
  rcht_pkg::count_t           cnt_wd;
  logic                       data_we;
  rcht_pkg::count_t           cnt_mod;
  rcht_pkg::handle_t          idx_handle;

  rcht_slot_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .used      (used),
    .free_slot (free_slot)
  );

  rcht_ram #(
    .WIDTH (rcht_pkg::COUNT_WIDTH),
    .DEPTH (rcht_pkg::SLOTS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (idx_r),
    .wr_data (cnt_wd),
    .rd_en   (accept),
    .rd_addr (rd_idx),
    .rd_data (cnt_rd)
  );

  rcht_ram #(
    .WIDTH (rcht_pkg::DATA_WIDTH),
    .DEPTH (rcht_pkg::SLOTS)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (idx_r),
    .wr_data (value_r),
    .rd_en   (accept),
    .rd_addr (rd_idx),
    .rd_data (data_rd)
  );

  assign accept     = start && (state_r == S_IDLE);
  assign idx_handle = rcht_pkg::HANDLE_WIDTH'(idx_r) + rcht_pkg::HANDLE_WIDTH'(1);

  always_comb begin
    rd_idx = rcht_pkg::IDX_WIDTH'(in_item.slot_handle - rcht_pkg::HANDLE_WIDTH'(1));
    if (in_item.opcode == rcht_pkg::OP_ALLOC) begin
      rd_idx = free_slot.idx;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    handle_nxt    = handle_r;
    value_nxt     = value_r;
    idx_nxt       = idx_r;
    full_nxt      = full_r;
    bad_nxt       = bad_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cnt_we        = 1'b0;
    cnt_wd        = '0;
    data_we       = 1'b0;
    cnt_mod       = '0;
    upd           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_EXEC;
          op_nxt     = in_item.opcode;
          handle_nxt = in_item.slot_handle;
          value_nxt  = in_item.item_value;
          idx_nxt    = rd_idx;
          full_nxt   = !free_slot.found;
          bad_nxt    = (in_item.slot_handle == '0)
                    || (in_item.slot_handle >
                        rcht_pkg::HANDLE_WIDTH'(rcht_pkg::SLOTS))
                    || !used[rd_idx];
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        case (op_r)
          rcht_pkg::OP_ALLOC: begin
            if (full_r) begin
              out_nxt.status = rcht_pkg::ST_FULL;
            end else begin
              cnt_we                = 1'b1;
              cnt_wd                = rcht_pkg::COUNT_WIDTH'(1);
              data_we               = 1'b1;
              upd.set               = 1'b1;
              upd.idx               = idx_r;
              out_nxt.result_handle = idx_handle;
              out_nxt.status        = rcht_pkg::ST_OK;
              out_nxt.ref_count     = rcht_pkg::COUNT_WIDTH'(1);
              out_nxt.slot_value    = value_r;
            end
          end
          rcht_pkg::OP_REF: begin
            out_nxt.result_handle = handle_r;
            if (bad_r) begin
              out_nxt.status = rcht_pkg::ST_BAD;
            end else if (cnt_rd == rcht_pkg::COUNT_MAX) begin
              out_nxt.status     = rcht_pkg::ST_SAT;
              out_nxt.ref_count  = cnt_rd;
              out_nxt.slot_value = data_rd;
            end else begin
              cnt_mod            = cnt_rd + rcht_pkg::COUNT_WIDTH'(1);
              cnt_we             = 1'b1;
              cnt_wd             = cnt_mod;
              out_nxt.status     = rcht_pkg::ST_OK;
              out_nxt.ref_count  = cnt_mod;
              out_nxt.slot_value = data_rd;
            end
          end
          rcht_pkg::OP_UNREF: begin
            out_nxt.result_handle = handle_r;
            if (bad_r) begin
              out_nxt.status = rcht_pkg::ST_BAD;
            end else begin
              cnt_mod            = cnt_rd - rcht_pkg::COUNT_WIDTH'(1);
              cnt_we             = 1'b1;
              cnt_wd             = cnt_mod;
              upd.clr            = (cnt_mod == '0);
              upd.idx            = idx_r;
              out_nxt.status     = rcht_pkg::ST_OK;
              out_nxt.ref_count  = cnt_mod;
              out_nxt.slot_freed = (cnt_mod == '0);
              out_nxt.slot_value = data_rd;
            end
          end
          default: begin
            out_nxt.status = rcht_pkg::ST_BAD;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    handle_r <= handle_nxt;
    value_r  <= value_nxt;
    idx_r    <= idx_nxt;
    full_r   <= full_nxt;
    bad_r    <= bad_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### design/rcht_ram.sv
module rcht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/rcht_slot_map.sv
module rcht_slot_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rcht_pkg::map_upd_t           upd,
  output logic [rcht_pkg::SLOTS-1:0]   used,
  output rcht_pkg::map_free_t          free_slot
);

  logic [rcht_pkg::SLOTS-1:0] used_r;
  logic [rcht_pkg::SLOTS-1:0] used_nxt;

  always_comb begin
    used_nxt = used_r;
    if (upd.set) begin
      used_nxt[upd.idx] = 1'b1;
    end
    if (upd.clr) begin
      used_nxt[upd.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_comb begin
    free_slot = '0;
    for (int i = rcht_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot.found = 1'b1;
        free_slot.idx   = rcht_pkg::IDX_WIDTH'(i);
      end
    end
  end

  assign used = used_r;

endmodule

### dv/refcounted_handle_table_core_tb.sv
module refcounted_handle_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcht_pkg::*;

  localparam opcode_t OP_UNKNOWN  = 2'd3;
  localparam int      CYCLE_LIMIT = 2_000_000;
  localparam int      SWEEP_HANDLE = 3;
  localparam int      SWEEP_DEPTH  = 20;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } table_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  count_t     model_count [SLOTS];
  data_t      model_data [SLOTS];
  out_item_t  expected_results [$];
  table_row_t directed_rows [$];

  int mismatches;
  int cycle_count;
  int n_sent, n_alloc, n_full, n_bad, n_sat, n_freed;

  refcounted_handle_table_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t make_result(int h, status_t st, count_t cnt, logic freed,
                                            data_t val);
    out_item_t r;
    r.result_handle = handle_t'(h);
    r.status        = st;
    r.ref_count     = cnt;
    r.slot_freed    = freed;
    r.slot_value    = val;
    return r;
  endfunction

  function automatic out_item_t predict_table_op(in_item_t it);
    out_item_t r;
    int        idx;
    r   = '0;
    idx = -1;
    case (it.opcode)
      OP_ALLOC: begin
        for (int s = SLOTS - 1; s >= 0; s--) if (model_count[s] == '0) idx = s;
        if (idx < 0) begin
          r.status = ST_FULL;
        end else begin
          model_count[idx] = count_t'(1);
          model_data[idx]  = it.item_value;
          r = make_result(idx + 1, ST_OK, count_t'(1), 1'b0, it.item_value);
        end
      end
      OP_REF, OP_UNREF: begin
        r.result_handle = it.slot_handle;
        idx = int'(it.slot_handle) - 1;
        if (it.slot_handle == '0 || it.slot_handle > SLOTS || model_count[idx] == '0) begin
          r.status = ST_BAD;
        end else if (it.opcode == OP_REF && model_count[idx] == COUNT_MAX) begin
          r.status     = ST_SAT;
          r.ref_count  = model_count[idx];
          r.slot_value = model_data[idx];
        end else begin
          if (it.opcode == OP_REF) model_count[idx] = model_count[idx] + 1'b1;
          else model_count[idx] = model_count[idx] - 1'b1;
          r.status     = ST_OK;
          r.ref_count  = model_count[idx];
          r.slot_freed = (it.opcode == OP_UNREF) && (model_count[idx] == '0);
          r.slot_value = model_data[idx];
        end
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  function automatic in_item_t random_transaction(int alloc_w, int ref_w, int unref_w);
    in_item_t it;
    int       roll;
    handle_t  live [$];
    it.opcode      = OP_ALLOC;
    it.slot_handle = handle_t'($urandom);
    it.item_value  = $urandom;
    roll = $urandom_range(0, 99);
    for (int s = 0; s < SLOTS; s++) if (model_count[s] != '0) live.push_back(handle_t'(s + 1));
    if ($urandom_range(0, 7) == 0) it.item_value = ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (roll < alloc_w) begin
      it.opcode = OP_ALLOC;
    end else if (roll < alloc_w + ref_w + unref_w) begin
      it.opcode = (roll < alloc_w + ref_w) ? OP_REF : OP_UNREF;
      if (live.size() != 0 && $urandom_range(0, 9) != 0)
        it.slot_handle = live[$urandom_range(0, live.size() - 1)];
      else
        it.slot_handle = handle_t'($urandom_range(1, SLOTS));
    end else if (roll < 97) begin
      it.opcode = ($urandom_range(0, 1) != 0) ? OP_REF : OP_UNREF;
    end else begin
      it.opcode = OP_UNKNOWN;
    end
    return it;
  endfunction

  task automatic add_row(opcode_t op, int h, data_t v, bit typed, out_item_t want);
    table_row_t row;
    row.stim.opcode      = op;
    row.stim.slot_handle = handle_t'(h);
    row.stim.item_value  = v;
    row.typed            = typed;
    row.want             = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_transaction(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = predict_table_op(it);
    expected_results.push_back(typed ? want : predicted);
    n_sent++;
    if (it.opcode == OP_ALLOC && predicted.status == ST_OK) n_alloc++;
    if (predicted.status == ST_FULL) n_full++;
    if (predicted.status == ST_BAD) n_bad++;
    if (predicted.status == ST_SAT) n_sat++;
    if (predicted.slot_freed) n_freed++;
  endtask

  task automatic idle_burst(bit enable);
    if (enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: handle %0d status %0d count %0d freed %0b value %h",
                 got.result_handle, got.status, got.ref_count, got.slot_freed, got.slot_value);
    end else begin
      want = expected_results.pop_front();
      if (got.result_handle !== want.result_handle || got.status !== want.status ||
          got.ref_count !== want.ref_count || got.slot_freed !== want.slot_freed ||
          got.slot_value !== want.slot_value) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected: handle %0d status %0d count %0d freed %0b value %h",
                   want.result_handle, want.status, want.ref_count, want.slot_freed,
                   want.slot_value);
          $display("         actual:   handle %0d status %0d count %0d freed %0b value %h",
                   got.result_handle, got.status, got.ref_count, got.slot_freed,
                   got.slot_value);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) check_result(out_item);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    bit       idle_on;
    int       alloc_w;
    int       unref_w;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    mismatches  = 0;
    cycle_count = 0;
    n_sent = 0; n_alloc = 0; n_full = 0; n_bad = 0; n_sat = 0; n_freed = 0;
    for (int s = 0; s < SLOTS; s++) begin
      model_count[s] = '0;
      model_data[s]  = '0;
    end

    add_row(OP_REF,     1,  32'h0,        1, make_result(1,  ST_BAD, '0, 1'b0, '0));
    add_row(OP_UNREF,   0,  32'h0,        1, make_result(0,  ST_BAD, '0, 1'b0, '0));
    add_row(OP_REF,     31, 32'h0,        1, make_result(31, ST_BAD, '0, 1'b0, '0));
    add_row(OP_UNREF,   17, 32'h0,        1, make_result(17, ST_BAD, '0, 1'b0, '0));
    add_row(OP_UNKNOWN, 5,  32'hDEADBEEF, 1, make_result(0,  ST_BAD, '0, 1'b0, '0));
    add_row(OP_ALLOC,   0,  32'h0,        1, make_result(1,  ST_OK,  16'd1, 1'b0, '0));
    add_row(OP_ALLOC,   31, 32'hFFFFFFFF, 1, make_result(2,  ST_OK,  16'd1, 1'b0, '1));
    add_row(OP_REF,     2,  32'h0,        1, make_result(2,  ST_OK,  16'd2, 1'b0, '1));
    add_row(OP_UNREF,   1,  32'h0,        1, make_result(1,  ST_OK,  '0,    1'b1, '0));
    add_row(OP_UNREF,   1,  32'h0,        1, make_result(1,  ST_BAD, '0,    1'b0, '0));
    add_row(OP_ALLOC,   0,  32'hA5A5A5A5, 1, make_result(1,  ST_OK,  16'd1, 1'b0, 32'hA5A5A5A5));
    for (int k = 0; k < SLOTS - 2; k++) add_row(OP_ALLOC, k, $urandom, 0, '0);
    add_row(OP_ALLOC,   7,  32'h12345678, 1, make_result(0,  ST_FULL, '0, 1'b0, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_transaction(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
      idle_burst(1'b1);
    end
    drain_results();

    it.opcode      = OP_REF;
    it.slot_handle = handle_t'(SWEEP_HANDLE);
    it.item_value  = '0;
    for (int k = 0; k < SWEEP_DEPTH; k++) send_transaction(it, 0, '0);
    it.opcode = OP_UNREF;
    for (int k = 0; k < SWEEP_DEPTH + 2; k++) send_transaction(it, 0, '0);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      alloc_w = (p % 2 == 0) ? 45 : 25;
      unref_w = (p % 2 == 0) ? 25 : 50;
      idle_on = (p < 6) && (p != 2);
      for (int k = 0; k < 190; k++) begin
        send_transaction(random_transaction(alloc_w, 15, unref_w), 0, '0);
        idle_burst(idle_on);
      end
      if (p == 1 || p == 4) drain_results();
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d transactions: %0d allocations, %0d table full, %0d bad handle or opcode",
             n_sent, n_alloc, n_full, n_bad);
    $display("%0d saturated references, %0d slots freed, one slot counted up and released",
             n_sat, n_freed);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
